// ===== hw/rtl/swm_pkg.sv =====
// ============================================================================
// swm_pkg
// Shared constants and controller/datapath interface types for the
// sliding-window maximum filter.
// ============================================================================
package swm_pkg;

    // Largest supported window and sample width.
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;

    // Derived widths.
    localparam int ADDR_BITS  = $clog2(WINDOW_MAX);
    localparam int POS_BITS   = $clog2(2 * WINDOW_MAX);
    localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int CFG_BITS   = 7;
    localparam int ENTRY_BITS = POS_BITS + SAMPLE_BITS;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_front;
        logic rd_back;
        logic drop_front;
        logic pop_back;
        logic append;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic front_aged;
        logic back_smaller;
        logic will_emit;
    } status_t;

endpackage

// ===== hw/rtl/swm_ram.sv =====
// ============================================================================
// swm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/swm_ctrl.sv =====
// ============================================================================
// swm_ctrl
// Controller for the sliding-window maximum filter. Sequences the front
// drop loop, the back pop loop, the append and the result hand-off.
// ============================================================================
module swm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  swm_pkg::status_t st,
    output swm_pkg::cmd_t    cmd
);
    import swm_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_FRONT_RD  = 3'd1;
    localparam logic [2:0] ST_FRONT_CHK = 3'd2;
    localparam logic [2:0] ST_BACK_RD   = 3'd3;
    localparam logic [2:0] ST_BACK_CHK  = 3'd4;
    localparam logic [2:0] ST_APPEND    = 3'd5;
    localparam logic [2:0] ST_OUT_RD    = 3'd6;
    localparam logic [2:0] ST_OUT_WAIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: begin
                if (st.count_zero) begin
                    state_next = ST_APPEND;
                end else begin
                    cmd.rd_front = 1'b1;
                    state_next   = ST_FRONT_CHK;
                end
            end
            ST_FRONT_CHK: begin
                if (st.front_aged) begin
                    cmd.drop_front = 1'b1;
                    state_next     = ST_FRONT_RD;
                end else begin
                    state_next = ST_BACK_RD;
                end
            end
            ST_BACK_RD: begin
                if (st.count_zero) begin
                    state_next = ST_APPEND;
                end else begin
                    cmd.rd_back = 1'b1;
                    state_next  = ST_BACK_CHK;
                end
            end
            ST_BACK_CHK: begin
                if (st.back_smaller) begin
                    cmd.pop_back = 1'b1;
                    state_next   = ST_BACK_RD;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = st.will_emit ? ST_OUT_RD : ST_IDLE;
            end
            ST_OUT_RD: begin
                cmd.rd_front = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/swm_dp.sv =====
// ============================================================================
// swm_dp
// Datapath for the sliding-window maximum filter: window register, deque
// pointers, candidate RAM, compare logic and output data register.
// ============================================================================
module swm_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [swm_pkg::CFG_BITS-1:0]          cfg_wr_data,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                  s_restart,
    input  swm_pkg::cmd_t                         cmd,
    output swm_pkg::status_t                      st,
    output logic signed [swm_pkg::SAMPLE_BITS-1:0] m_window_max
);
    import swm_pkg::*;

    logic [CFG_BITS-1:0]           ws_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [ADDR_BITS-1:0]          head_reg, head_next;
    logic [CNT_BITS-1:0]           count_reg, count_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [CNT_BITS-1:0]           fill_reg, fill_next;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic [CNT_BITS-1:0]           win;
    logic [CNT_BITS-1:0]           fill_inc;
    logic [ADDR_BITS-1:0]          back_addr;
    logic [ADDR_BITS-1:0]          tail_addr;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic [ENTRY_BITS-1:0]         rd_data;
    logic [POS_BITS-1:0]           rd_pos;
    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic [POS_BITS-1:0]           age;
    logic                          clear_hist;

    // Effective window length: zero acts as one, large values clamp.
    always_comb begin
        if (ws_reg == '0) begin
            win = CNT_BITS'(1);
        end else if (CNT_BITS'(ws_reg) > CNT_BITS'(WINDOW_MAX)) begin
            win = CNT_BITS'(WINDOW_MAX);
        end else begin
            win = CNT_BITS'(ws_reg);
        end
    end

    // Deque addresses, modulo the RAM depth.
    assign back_addr = head_reg + count_reg[ADDR_BITS-1:0] - ADDR_BITS'(1);
    assign tail_addr = head_reg + count_reg[ADDR_BITS-1:0];
    assign rd_addr   = cmd.rd_back ? back_addr : head_reg;

    swm_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(WINDOW_MAX)
    ) u_cand_ram (
        .aclk (aclk),
        .we   (cmd.append),
        .waddr(tail_addr),
        .wdata({pos_reg, sample_reg}),
        .re   (cmd.rd_front | cmd.rd_back),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign rd_pos   = rd_data[ENTRY_BITS-1:SAMPLE_BITS];
    assign rd_value = rd_data[SAMPLE_BITS-1:0];

    // Age wraps naturally in the position width.
    assign age = pos_reg - rd_pos;

    // Fill count after this sample, saturating at the window length.
    assign fill_inc = (fill_reg < win) ? (fill_reg + CNT_BITS'(1)) : win;

    // Status back to the controller.
    assign st.count_zero   = (count_reg == '0);
    assign st.front_aged   = (CNT_BITS'(age) >= win);
    assign st.back_smaller = (rd_value < sample_reg);
    assign st.will_emit    = (fill_inc == win);

    // A restart with the accepted sample, or a window write, clears history.
    assign clear_hist = cfg_wr_en || (cmd.accept && s_restart);

    // Deque pointer updates.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        if (clear_hist) begin
            head_next  = '0;
            count_next = '0;
            pos_next   = '0;
            fill_next  = '0;
        end else if (cmd.drop_front) begin
            head_next  = head_reg + ADDR_BITS'(1);
            count_next = count_reg - CNT_BITS'(1);
        end else if (cmd.pop_back) begin
            count_next = count_reg - CNT_BITS'(1);
        end else if (cmd.append) begin
            if (count_reg < CNT_BITS'(WINDOW_MAX)) begin
                count_next = count_reg + CNT_BITS'(1);
            end
            pos_next  = pos_reg + POS_BITS'(1);
            fill_next = fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg    <= CFG_BITS'(1);
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                ws_reg <= cfg_wr_data;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
        end
    end

    // Payload registers: latched sample and output data.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.load_out) begin
            out_reg <= rd_value;
        end
    end

    assign m_window_max = out_reg;

endmodule

// ===== hw/rtl/sliding_window_maximum_core.sv =====
// ============================================================================
// sliding_window_maximum_core
// Running maximum filter over a stream of signed samples, built on a
// monotonic deque of candidates held in a RAM.
// ============================================================================
// The block takes one sample at a time and, once window_size samples of the
// current sequence have been seen, returns the largest of the last
// window_size samples. Each sample walks the deque one entry at a time
// through the single read port of the candidate RAM: aged candidates are
// dropped from the front, smaller candidates are popped from the back, and
// the sample is appended. When the deque is empty, either on arrival or after
// the drops, the pop pass is skipped. When a result is produced the front is
// read once more and loaded into the output register, once the previous
// result has been taken. A new sample is accepted while an earlier result
// still waits in the output register. Writing window_size clears the
// history, as does a sample with restart set; a window_size of zero acts as
// one and values above 64 act as 64. Write the configuration only while the
// block is idle.
module sliding_window_maximum_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [swm_pkg::CFG_BITS-1:0]           cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                   s_restart,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [swm_pkg::SAMPLE_BITS-1:0] m_window_max
);
    import swm_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Controller: sequences each transaction through the deque.
    swm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .st     (st),
        .cmd    (cmd)
    );

    // Datapath: deque storage, pointers and compares.
    swm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_sample),
        .s_restart   (s_restart),
        .cmd         (cmd),
        .st          (st),
        .m_window_max(m_window_max)
    );

    // Only one deque update happens in any cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.drop_front, cmd.pop_back, cmd.append}))
        else $error("more than one deque update in a cycle");

    // After an append the deque holds at least the new candidate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append && !cfg_wr_en |=> !st.count_zero)
        else $error("deque empty after append");

    // A sample with restart starts from an empty deque.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart |=> st.count_zero)
        else $error("deque not cleared by restart");

    // Loading the output register always presents a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result loaded but not presented");

endmodule

// ===== test/sliding_window_maximum_core_tb.sv =====
// ============================================================================
// sliding_window_maximum_core_tb
// Self-checking testbench for the sliding-window maximum filter: a directed
// opening, then randomized sample streams over a range of window lengths,
// each result checked against a cycle-free deque predictor.
// ============================================================================
`timescale 1ns / 1ps

module sliding_window_maximum_core_tb;
    import swm_pkg::*;

    // Longest time one sample can keep the block busy, with margin.
    localparam int SETTLE_CYCLES = 200;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_COUNT = 11;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } sample_item_t;

    // Shapes of random sample runs.
    typedef enum int {
        PAT_UNIFORM,
        PAT_NARROW,
        PAT_FALLING,
        PAT_RISING,
        PAT_EXTREME
    } pattern_t;

    // DUT ports; the inputs are all known from time zero.
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0]           cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample    = '0;
    logic                          s_restart   = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_window_max;

    // Stimulus and scoreboard state.
    sample_item_t                  pending_samples[$];
    logic signed [SAMPLE_BITS-1:0] expected_max[$];
    sample_item_t                  next_item;
    logic signed [SAMPLE_BITS-1:0] predicted_max;
    logic signed [SAMPLE_BITS-1:0] wanted_max;
    bit                            s_fire = 1'b0;
    int                            idle_pct = 24;
    int                            samples_sent = 0;
    int                            samples_taken = 0;
    int                            maxima_checked = 0;
    int                            window_writes = 0;
    int                            error_count = 0;
    int                            idle_cycles = 0;

    // Predictor state: the candidate deque, oldest first.
    logic signed [SAMPLE_BITS-1:0] cand_val[WINDOW_MAX];
    logic [POS_BITS-1:0]           cand_pos[WINDOW_MAX];
    logic [ADDR_BITS-1:0]          front;
    logic [CNT_BITS-1:0]           cand_count;
    logic [POS_BITS-1:0]           next_pos;
    logic [CNT_BITS-1:0]           fill;
    logic [CFG_BITS-1:0]           win_len;

    sliding_window_maximum_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_window_max(m_window_max)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Forget the sequence so far; the next sample starts a new one.
    function automatic void clear_history();
        front      = '0;
        cand_count = '0;
        next_pos   = '0;
        fill       = '0;
    endfunction

    // Advance the deque by one sample. Returns 1 when a full window has been
    // seen, with the window maximum in max_out.
    function automatic bit next_window_max(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic restart,
                                           output logic signed [SAMPLE_BITS-1:0] max_out);
        logic [CNT_BITS-1:0]  span;
        logic [POS_BITS-1:0]  age;
        logic [ADDR_BITS-1:0] slot;
        bit                   stop;
        // A length of zero behaves as one; anything past the RAM depth saturates.
        if (win_len == 0) begin
            span = CNT_BITS'(1);
        end else if (win_len > WINDOW_MAX) begin
            span = CNT_BITS'(WINDOW_MAX);
        end else begin
            span = win_len;
        end
        if (restart) begin
            clear_history();
        end

        // Drop candidates that have aged out of the window.
        stop = 1'b0;
        while (cand_count != 0 && !stop) begin
            age = next_pos - cand_pos[front];
            if (age < span) begin
                stop = 1'b1;
            end else begin
                front      = front + 1'b1;
                cand_count = cand_count - 1'b1;
            end
        end

        // Pop strictly smaller candidates from the back; equal ones stay.
        stop = 1'b0;
        while (cand_count != 0 && !stop) begin
            slot = front + cand_count[ADDR_BITS-1:0] - 1'b1;
            if (cand_val[slot] >= smp) begin
                stop = 1'b1;
            end else begin
                cand_count = cand_count - 1'b1;
            end
        end

        // Append the new sample.
        slot           = front + cand_count[ADDR_BITS-1:0];
        cand_val[slot] = smp;
        cand_pos[slot] = next_pos;
        if (cand_count < WINDOW_MAX) begin
            cand_count = cand_count + 1'b1;
        end
        next_pos = next_pos + 1'b1;
        if (fill < span) begin
            fill = fill + 1'b1;
        end
        max_out = cand_val[front];
        return fill == span;
    endfunction

    // Driver: presents queued samples and randomizes result back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_fire) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_item = pending_samples.pop_front();
                    s_valid   <= 1'b1;
                    s_sample  <= next_item.sample;
                    s_restart <= next_item.restart;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: tracks configuration and sample transactions, checks results.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire      = 1'b0;
            idle_cycles = 0;
        end else begin
            s_fire = s_valid && s_ready;
            if (cfg_wr_en) begin
                win_len = cfg_wr_data;
                clear_history();
            end
            if (s_fire) begin
                samples_taken++;
                if (next_window_max(s_sample, s_restart, predicted_max)) begin
                    expected_max = {expected_max, predicted_max};
                end
            end
            if (m_valid && m_ready) begin
                if (expected_max.size() == 0) begin
                    error_count++;
                    $error("window_max: expected nothing, got %0d", m_window_max);
                end else begin
                    wanted_max = expected_max.pop_front();
                    maxima_checked++;
                    if (m_window_max !== wanted_max) begin
                        error_count++;
                        $error("window_max: expected %0d, got %0d", wanted_max, m_window_max);
                    end
                end
            end

            // Watchdog on transaction activity.
            if (s_fire || (m_valid && m_ready) || cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic restart);
        sample_item_t item;
        item.sample  = smp;
        item.restart = restart;
        pending_samples = {pending_samples, item};
        samples_sent++;
    endtask

    // Wait until every sample is taken and every predicted maximum has arrived.
    task automatic wait_drained();
        while (samples_taken != samples_sent || expected_max.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Change the window length once the block has gone quiet.
    task automatic write_window(input logic [CFG_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        window_writes++;
    endtask

    // Stimulus sequence.
    initial begin
        int unsigned                   window_plan[PHASE_COUNT] =
            '{64, 0, 127, 2, 65, 42, 85, 7, 1, 16, 0};
        logic [CFG_BITS-1:0]           win;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [SAMPLE_BITS-1:0] ramp;
        pattern_t                      pattern;
        int                            run_left;
        int                            item_count;
        int                            restart_permille;
        bit                            big;

        win_len = CFG_BITS'(1);
        clear_history();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes with the reset window length of one.
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b1);

        // Directed: window of three covering fill-up, aging out, popping,
        // equal samples and a restart in the middle of a window.
        write_window(7'd3);
        queue_sample(16'sd5, 1'b1);
        queue_sample(16'sd4, 1'b0);
        queue_sample(16'sd3, 1'b0);
        queue_sample(16'sd2, 1'b0);
        queue_sample(16'sd10, 1'b0);
        queue_sample(16'sd10, 1'b0);
        queue_sample(16'sd10, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);

        // Random phases, one window length each, in runs of shaped samples.
        run_left = 0;
        ramp     = '0;
        pattern  = PAT_UNIFORM;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            win = (ph == PHASE_COUNT - 1) ? CFG_BITS'($urandom_range(127))
                                          : CFG_BITS'(window_plan[ph]);
            write_window(win);
            // One phase runs with no idling on either side.
            idle_pct         = (ph == 5) ? 0 : 24;
            big              = (win >= 32);
            item_count       = big ? 80 : 25;
            restart_permille = big ? 4 : 50;
            for (int i = 0; i < item_count; i++) begin
                // Hold the sender once until the block has emptied completely.
                if (ph == 4 && i == 40) begin
                    wait_drained();
                end
                if (run_left == 0) begin
                    pattern  = pattern_t'($urandom_range(PAT_EXTREME));
                    run_left = $urandom_range(40, 5);
                    ramp     = SAMPLE_BITS'($urandom);
                end
                run_left--;
                case (pattern)
                    PAT_UNIFORM: begin
                        smp = SAMPLE_BITS'($urandom);
                    end
                    PAT_NARROW: begin
                        smp = SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
                    end
                    PAT_FALLING: begin
                        ramp = ramp - SAMPLE_BITS'($urandom_range(3));
                        smp  = ramp;
                    end
                    PAT_RISING: begin
                        ramp = ramp + SAMPLE_BITS'($urandom_range(3));
                        smp  = ramp;
                    end
                    default: begin
                        smp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    end
                endcase
                queue_sample(smp, ($urandom_range(999) < restart_permille));
            end
        end

        // Drain, then give the block time to show any stray result.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d samples across %0d window length settings,",
                 samples_taken, window_writes);
        $display("with %0d window maxima compared against the predictor.", maxima_checked);
        if (error_count == 0 && expected_max.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
